FILE: src/mhn_pkg.sv
// mhn_pkg: shared constants and types for the held-note tracker
// message codes, the "none" value and the result record
// no dependencies
package mhn_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int HELD_W         = 5;

	localparam logic [2:0] OP_NOTE_ON       = 3'd0;
	localparam logic [2:0] OP_NOTE_OFF      = 3'd1;
	localparam logic [2:0] OP_POLY_PRESSURE = 3'd2;
	localparam logic [2:0] OP_CHAN_PRESSURE = 3'd3;

	localparam logic signed [7:0] NONE_VALUE = -8'sd1;

	typedef struct packed {
		logic [HELD_W-1:0] held_count;
		logic signed [7:0] newest_note;
		logic signed [7:0] velocity_now;
		logic signed [7:0] pressure_now;
		logic              trigger_pulse;
		logic              overflow;
	} res_t;

endpackage

FILE: src/mhn_note_mem.sv
// mhn_note_mem: storage for the held-note list
// one write port, one read port with registered read data
// no package dependencies
module mhn_note_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [6:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [6:0]    rdata
);

	logic [6:0] mem_q [DEPTH];
	logic [6:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: src/mhn_seq.sv
// mhn_seq: sequencer for the held-note list
// walks the list one entry per cycle with a single compare unit, then shifts
// depends on mhn_pkg and drives mhn_note_mem
module mhn_seq #(
	parameter int LIST_DEPTH = 16,
	parameter int AW         = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [2:0]    op,
	input  logic [6:0]    data_first,
	input  logic [6:0]    data_second,
	output logic          res_valid,
	input  logic          res_take,
	output mhn_pkg::res_t res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [6:0]    mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [6:0]    mem_rdata
);
	import mhn_pkg::*;

	localparam int CW = $clog2(LIST_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SHIFT,
		ST_FETCH,
		ST_LOAD,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     total_q;
	logic [CW-1:0]     idx_q;
	logic [6:0]        key_q;
	logic signed [7:0] vel_q;
	logic signed [7:0] pres_q;
	logic signed [7:0] newest_q;
	logic              trig_q;
	logic              ovf_q;

	logic              accept;
	logic              full;
	logic [CW:0]       idx_p1;
	logic [CW:0]       idx_p2;
	logic [CW-1:0]     total_m1;
	logic              more;
	logic [CW+4:0]     count_ext;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign full     = (total_q == CW'(LIST_DEPTH));
	assign idx_p1   = {1'b0, idx_q} + (CW+1)'(1);
	assign idx_p2   = {1'b0, idx_q} + (CW+1)'(2);
	assign total_m1 = total_q - CW'(1);
	// entry idx+1 still inside the list
	assign more     = (idx_p1 < {1'b0, total_q});

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_raddr = idx_p1[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				mem_waddr = total_q[AW-1:0];
				mem_wdata = data_first;
				mem_raddr = '0;
				mem_we    = accept && (op == OP_NOTE_ON) && !full;
			end
			ST_SHIFT: begin
				mem_we    = more;
				mem_raddr = idx_p2[AW-1:0];
			end
			ST_FETCH: begin
				mem_raddr = total_q[AW-1:0] - AW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			total_q  <= '0;
			idx_q    <= '0;
			vel_q    <= NONE_VALUE;
			pres_q   <= NONE_VALUE;
			newest_q <= NONE_VALUE;
			trig_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						trig_q  <= 1'b0;
						ovf_q   <= 1'b0;
						key_q   <= data_first;
						idx_q   <= '0;
						state_q <= ST_DONE;
						case (op)
							OP_NOTE_ON: begin
								trig_q <= 1'b1;
								vel_q  <= {1'b0, data_second};
								if (full) begin
									ovf_q <= 1'b1;
								end else begin
									total_q  <= total_q + CW'(1);
									newest_q <= {1'b0, data_first};
								end
							end
							OP_NOTE_OFF: begin
								if (total_q == '0) begin
									vel_q  <= NONE_VALUE;
									pres_q <= NONE_VALUE;
								end else begin
									state_q <= ST_SEARCH;
								end
							end
							OP_POLY_PRESSURE: pres_q <= {1'b0, data_second};
							OP_CHAN_PRESSURE: pres_q <= {1'b0, data_first};
							default: begin
							end
						endcase
					end
				end
				ST_SEARCH: begin
					if (mem_rdata == key_q) begin
						state_q <= ST_SHIFT;
					end else if (more) begin
						idx_q <= idx_p1[CW-1:0];
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_SHIFT: begin
					if (more) begin
						idx_q <= idx_p1[CW-1:0];
					end else begin
						total_q <= total_m1;
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (total_q == '0) begin
						newest_q <= NONE_VALUE;
						vel_q    <= NONE_VALUE;
						pres_q   <= NONE_VALUE;
					end else begin
						newest_q <= {1'b0, mem_rdata};
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign count_ext = (CW+5)'(total_q);

	assign res_valid         = (state_q == ST_DONE);
	assign res.held_count    = count_ext[HELD_W-1:0];
	assign res.newest_note   = newest_q;
	assign res.velocity_now  = vel_q;
	assign res.pressure_now  = pres_q;
	assign res.trigger_pulse = trig_q;
	assign res.overflow      = ovf_q;

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(LIST_DEPTH))
		else $error("held total beyond list depth");

	a_empty_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && total_q == '0) |=>
		(vel_q == NONE_VALUE && pres_q == NONE_VALUE && newest_q == NONE_VALUE))
		else $error("empty list did not clear velocity and pressure");

	a_remove_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && !more) |=> (total_q == $past(total_m1)))
		else $error("removal did not drop exactly one entry");

	a_write_where: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_IDLE || state_q == ST_SHIFT))
		else $error("list written outside append or shift");

endmodule

FILE: src/midi_held_note_tracker.sv
// Held-note tracker for decoded MIDI channel messages.
// Input channel: in_valid / in_stall with op, data_first, data_second; a
// transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with held_count, newest_note,
// velocity_now, pressure_now, trigger_pulse, overflow; one result per message.
// Note-on, pressure and ignored codes pass through the sequencer result
// registers to the output register. Note-off walks the list one entry per cycle
// through a single compare unit, then shifts the later entries down one per
// cycle through the one-read, one-write list memory, then fetches the new
// newest note (search, shift, fetch, load states); when the note is not held
// it stops after the search, and an empty list skips the search.
// in_stall is high while a message is in work and while its result waits
// for room in the output register. The output register is separate, so the
// next message is taken while an earlier result still sits on the outputs.
// When out_stall is high the result holds and the block stops once the
// following result is also finished.
// Reset: held count 0, velocity and pressure -1, no result pending. The list
// memory is not cleared; only entries below the count are ever used.
// depends on mhn_pkg, mhn_seq, mhn_note_mem
module midi_held_note_tracker #(
	parameter int LIST_DEPTH = mhn_pkg::LIST_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [2:0]        op,
	input  logic [6:0]        data_first,
	input  logic [6:0]        data_second,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [4:0]        held_count,
	output logic signed [7:0] newest_note,
	output logic signed [7:0] velocity_now,
	output logic signed [7:0] pressure_now,
	output logic              trigger_pulse,
	output logic              overflow
);
	import mhn_pkg::*;

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

	logic          res_valid;
	logic          res_take;
	res_t          res;
	res_t          out_q;
	logic          out_valid_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [6:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [6:0]    mem_rdata;

	mhn_seq #(
		.LIST_DEPTH (LIST_DEPTH),
		.AW         (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.data_first  (data_first),
		.data_second (data_second),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	mhn_note_mem #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// load the output register when it is empty or its transfer completes
	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign held_count    = out_q.held_count;
	assign newest_note   = out_q.newest_note;
	assign velocity_now  = out_q.velocity_now;
	assign pressure_now  = out_q.pressure_now;
	assign trigger_pulse = out_q.trigger_pulse;
	assign overflow      = out_q.overflow;

endmodule
